### design/triangle_face_normal_assert.svh
// Assertion helpers used by the checker file tfn_checker.sv.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define TFN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("triangle_face_normal check failed");

// Next-cycle implication, disabled while reset is applied.
`define TFN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("triangle_face_normal check failed");

`endif

### design/tfn_pkg.sv
package tfn_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // After block scaling the largest magnitude sits in [2^29, 2^30).
    localparam int SCALE_TOP  = 29;
    localparam int A_W        = SCALE_TOP + 1;
    localparam int S_W        = 2 * A_W + 2;
    localparam int L_W        = S_W / 2;
    localparam int REM_W      = L_W + 2;
    localparam int SQRT_STEPS = L_W;

    typedef logic [2:0][A_W-1:0] t_avec;

    typedef struct packed {
        logic       deg;
        logic [2:0] sgn;
        t_avec      a;
    } t_sq_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [L_W-1:0]   root;
        logic [S_W-1:0]   rad;
    } t_sq_work;

    typedef struct packed {
        logic           deg;
        logic [2:0]     sgn;
        logic [L_W-1:0] len;
    } t_div_side;

endpackage

### design/tfn_sqrt_cell.sv
module tfn_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tfn_pkg::t_sq_side  i_side,
    input  tfn_pkg::t_sq_work  i_work,
    output logic               o_valid,
    output tfn_pkg::t_sq_side  o_side,
    output tfn_pkg::t_sq_work  o_work
);

    localparam int RW = tfn_pkg::REM_W;
    localparam int LW = tfn_pkg::L_W;
    localparam int SW = tfn_pkg::S_W;

    logic              r_valid;
    tfn_pkg::t_sq_side r_side;
    tfn_pkg::t_sq_work r_work;
    tfn_pkg::t_sq_work n_work;
    logic [RW+1:0]     rsh;
    logic [RW+1:0]     trial;
    logic [RW+1:0]     diff;
    logic              fit;

    // One root bit per cell: bring down two radicand bits, try 4*root+1.
    always_comb begin
        rsh   = {i_work.rem, i_work.rad[SW-1 -: 2]};
        trial = {2'b00, i_work.root, 2'b01};
        diff  = rsh - trial;
        fit   = (rsh >= trial);
        n_work.rem  = fit ? diff[RW-1:0] : rsh[RW-1:0];
        n_work.root = {i_work.root[LW-2:0], fit};
        n_work.rad  = {i_work.rad[SW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_work <= n_work;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_work  = r_work;

endmodule

### design/tfn_div_cell.sv
module tfn_div_cell #(
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  tfn_pkg::t_div_side                     i_side,
    input  logic [2:0][tfn_pkg::L_W-1:0]           i_rem,
    input  logic [2:0][NORMAL_FRAC_BITS:0]         i_nq,
    output logic                                   o_valid,
    output tfn_pkg::t_div_side                     o_side,
    output logic [2:0][tfn_pkg::L_W-1:0]           o_rem,
    output logic [2:0][NORMAL_FRAC_BITS:0]         o_nq
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int LW = tfn_pkg::L_W;

    logic                          r_valid;
    tfn_pkg::t_div_side            r_side;
    logic [2:0][LW-1:0]            r_rem;
    logic [2:0][F:0]               r_nq;
    logic [2:0][LW-1:0]            n_rem;
    logic [2:0][F:0]               n_nq;
    logic [2:0][LW:0]              r2;
    logic [2:0][LW:0]              diff;
    logic [2:0]                    ge;

    // Shift in the next dividend bit, subtract the length where it fits;
    // quotient bits fill in from the bottom as dividend bits leave the top.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            r2[j]    = {i_rem[j], i_nq[j][F]};
            diff[j]  = r2[j] - {1'b0, i_side.len};
            ge[j]    = (r2[j] >= {1'b0, i_side.len});
            n_rem[j] = ge[j] ? diff[j][LW-1:0] : r2[j][LW-1:0];
            n_nq[j]  = {i_nq[j][F-1:0], ge[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_rem  <= n_rem;
        r_nq   <= n_nq;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;

endmodule

### design/triangle_face_normal.sv
// Throughput: one triangle per cycle; busy is low outside reset and results never stall.
// Seven front stages, 31 square-root cells, one divider setup register,
// NORMAL_FRAC_BITS + 1 divider cells and one output register set the latency.
// Each cell retires one result bit.
// Reset (i_rst_n low, synchronous) drops all transactions in flight and holds busy high.
module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_BITS-1:0]       i_first_x,
    input  logic signed [COORD_BITS-1:0]       i_first_y,
    input  logic signed [COORD_BITS-1:0]       i_first_z,
    input  logic signed [COORD_BITS-1:0]       i_second_x,
    input  logic signed [COORD_BITS-1:0]       i_second_y,
    input  logic signed [COORD_BITS-1:0]       i_second_z,
    input  logic signed [COORD_BITS-1:0]       i_third_x,
    input  logic signed [COORD_BITS-1:0]       i_third_y,
    input  logic signed [COORD_BITS-1:0]       i_third_z,
    output logic                               o_valid,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_z,
    output logic                               o_degenerate
);

    localparam int CB   = COORD_BITS;
    localparam int F    = NORMAL_FRAC_BITS;
    localparam int E_W  = CB + 1;
    localparam int P_W  = 2 * E_W;
    localparam int C_W  = P_W + 1;
    localparam int AW   = P_W;
    localparam int MS_W = $clog2(AW);
    localparam int A_W  = tfn_pkg::A_W;
    localparam int S_W  = tfn_pkg::S_W;
    localparam int L_W  = tfn_pkg::L_W;
    localparam int O_W  = F + 2;
    localparam int N_W  = A_W + F + 1;
    localparam int NS   = tfn_pkg::SQRT_STEPS;
    localparam int ND   = F + 1;

    logic r_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    logic accept;
    assign accept = start && !r_busy;

    // Stage 1: edges
    logic [7:1] r_v;
    logic signed [2:0][E_W-1:0] r_e1, r_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:1], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1[0] <= E_W'(i_first_x) - E_W'(i_third_x);
        r_e1[1] <= E_W'(i_first_y) - E_W'(i_third_y);
        r_e1[2] <= E_W'(i_first_z) - E_W'(i_third_z);
        r_e2[0] <= E_W'(i_third_x) - E_W'(i_second_x);
        r_e2[1] <= E_W'(i_third_y) - E_W'(i_second_y);
        r_e2[2] <= E_W'(i_third_z) - E_W'(i_second_z);
    end

    // Stage 2: cross-product partial products
    logic signed [P_W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    always_ff @(posedge i_clk) begin
        r_p0 <= $signed(r_e1[1]) * $signed(r_e2[2]);
        r_p1 <= $signed(r_e1[2]) * $signed(r_e2[1]);
        r_p2 <= $signed(r_e1[2]) * $signed(r_e2[0]);
        r_p3 <= $signed(r_e1[0]) * $signed(r_e2[2]);
        r_p4 <= $signed(r_e1[0]) * $signed(r_e2[1]);
        r_p5 <= $signed(r_e1[1]) * $signed(r_e2[0]);
    end

    // Stage 3: components, magnitudes, signs
    logic signed [2:0][C_W-1:0] cc;
    logic [2:0][AW-1:0]         r_a3;
    logic [2:0]                 r_sgn3;
    logic                       r_deg3;

    assign cc[0] = C_W'(r_p0) - C_W'(r_p1);
    assign cc[1] = C_W'(r_p2) - C_W'(r_p3);
    assign cc[2] = C_W'(r_p4) - C_W'(r_p5);

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_a3[j]   <= cc[j][C_W-1] ? AW'(-$signed(cc[j])) : AW'(cc[j]);
            r_sgn3[j] <= cc[j][C_W-1];
        end
        r_deg3 <= (cc[0] == '0) && (cc[1] == '0) && (cc[2] == '0);
    end

    // Stage 4: top set bit of the largest magnitude (same as of the OR)
    logic [AW-1:0]      or_all;
    logic [MS_W-1:0]    msb;
    logic [2:0][AW-1:0] r_a4;
    logic [MS_W-1:0]    r_msb4;
    logic [2:0]         r_sgn4;
    logic               r_deg4;

    always_comb begin
        or_all = r_a3[0] | r_a3[1] | r_a3[2];
        msb    = '0;
        for (int i = 0; i < AW; i++) begin
            if (or_all[i]) begin
                msb = MS_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a4   <= r_a3;
        r_msb4 <= msb;
        r_sgn4 <= r_sgn3;
        r_deg4 <= r_deg3;
    end

    // Stage 5: block scaling to 30 bits, truncating when shifting right
    logic [MS_W-1:0]     lsh;
    logic [2:0][AW-1:0]  xs;
    tfn_pkg::t_avec      sc;
    tfn_pkg::t_avec      r_a5;
    logic [2:0]          r_sgn5;
    logic                r_deg5;

    assign lsh = MS_W'(AW - 1) - r_msb4;

    for (genvar j = 0; j < 3; j++) begin : g_scale
        assign xs[j] = r_a4[j] << lsh;
        if (AW >= A_W) begin : g_trunc
            assign sc[j] = xs[j][AW-1 -: A_W];
        end else begin : g_pad
            assign sc[j] = {xs[j], {(A_W - AW){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a5   <= sc;
        r_sgn5 <= r_sgn4;
        r_deg5 <= r_deg4;
    end

    // Stage 6: squares
    logic [2:0][2*A_W-1:0] r_sq6;
    tfn_pkg::t_avec        r_a6;
    logic [2:0]            r_sgn6;
    logic                  r_deg6;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_sq6[j] <= r_a5[j] * r_a5[j];
        end
        r_a6   <= r_a5;
        r_sgn6 <= r_sgn5;
        r_deg6 <= r_deg5;
    end

    // Stage 7: sum of squares
    logic [S_W-1:0]   r_s7;
    tfn_pkg::t_avec   r_a7;
    logic [2:0]       r_sgn7;
    logic             r_deg7;

    always_ff @(posedge i_clk) begin
        r_s7   <= S_W'(r_sq6[0]) + S_W'(r_sq6[1]) + S_W'(r_sq6[2]);
        r_a7   <= r_a6;
        r_sgn7 <= r_sgn6;
        r_deg7 <= r_deg6;
    end

    // Square-root chain
    logic [NS:0]               sq_v;
    tfn_pkg::t_sq_side [NS:0]  sq_side;
    tfn_pkg::t_sq_work [NS:0]  sq_work;

    assign sq_v[0]         = r_v[7];
    assign sq_side[0].deg  = r_deg7;
    assign sq_side[0].sgn  = r_sgn7;
    assign sq_side[0].a    = r_a7;
    assign sq_work[0].rem  = '0;
    assign sq_work[0].root = '0;
    assign sq_work[0].rad  = r_s7;

    for (genvar i = 0; i < NS; i++) begin : g_sqrt
        tfn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[i]),
            .i_side  (sq_side[i]),
            .i_work  (sq_work[i]),
            .o_valid (sq_v[i+1]),
            .o_side  (sq_side[i+1]),
            .o_work  (sq_work[i+1])
        );
    end

    // Divider setup: dividend a * 2^F + L/2, leading part preloaded
    logic [L_W-1:0]          len;
    logic [2:0][N_W-1:0]     num;
    logic [ND:0]             dv_v;
    tfn_pkg::t_div_side [ND:0]      dv_side;
    logic [ND:0][2:0][L_W-1:0]      dv_rem;
    logic [ND:0][2:0][F:0]          dv_nq;
    logic                           r_dv_v;
    tfn_pkg::t_div_side             r_dv_side;
    logic [2:0][L_W-1:0]            r_dv_rem;
    logic [2:0][F:0]                r_dv_nq;

    assign len = sq_work[NS].root;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            num[j] = {1'b0, sq_side[NS].a[j], {F{1'b0}}} + N_W'(len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v <= 1'b0;
        end else begin
            r_dv_v <= sq_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_side.deg <= sq_side[NS].deg;
        r_dv_side.sgn <= sq_side[NS].sgn;
        r_dv_side.len <= len;
        for (int j = 0; j < 3; j++) begin
            r_dv_rem[j] <= L_W'(num[j][N_W-1:F+1]);
            r_dv_nq[j]  <= num[j][F:0];
        end
    end

    assign dv_v[0]    = r_dv_v;
    assign dv_side[0] = r_dv_side;
    assign dv_rem[0]  = r_dv_rem;
    assign dv_nq[0]   = r_dv_nq;

    for (genvar i = 0; i < ND; i++) begin : g_div
        tfn_div_cell #(
            .NORMAL_FRAC_BITS (F)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[i]),
            .i_side  (dv_side[i]),
            .i_rem   (dv_rem[i]),
            .i_nq    (dv_nq[i]),
            .o_valid (dv_v[i+1]),
            .o_side  (dv_side[i+1]),
            .o_rem   (dv_rem[i+1]),
            .o_nq    (dv_nq[i+1])
        );
    end

    // Output: saturate, apply sign, zero on degenerate
    localparam logic [F:0] ONE = (F+1)'(1) << F;
    logic [2:0][F:0]     qs;
    logic [2:0][O_W-1:0] n_out;
    logic                r_ovalid;
    logic [2:0][O_W-1:0] r_out;
    logic                r_odeg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            qs[j] = (dv_nq[ND][j] > ONE) ? ONE : dv_nq[ND][j];
            if (dv_side[ND].deg) begin
                n_out[j] = '0;
            end else if (dv_side[ND].sgn[j]) begin
                n_out[j] = O_W'(0) - O_W'(qs[j]);
            end else begin
                n_out[j] = O_W'(qs[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= dv_v[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_odeg <= dv_side[ND].deg;
    end

    assign o_valid      = r_ovalid;
    assign o_normal_x   = r_out[0];
    assign o_normal_y   = r_out[1];
    assign o_normal_z   = r_out[2];
    assign o_degenerate = r_odeg;

endmodule

### design/tfn_checker.sv
`include "triangle_face_normal_assert.svh"

module tfn_checker #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [COORD_BITS-1:0]       i_first_x,
    input logic signed [NORMAL_FRAC_BITS+1:0] o_normal_x,
    input logic signed [NORMAL_FRAC_BITS+1:0] o_normal_y,
    input logic signed [NORMAL_FRAC_BITS+1:0] o_normal_z,
    input logic                               o_valid,
    input logic                               o_degenerate
);

    localparam int LAT = NORMAL_FRAC_BITS + 41;
    localparam logic signed [NORMAL_FRAC_BITS+1:0] ONE =
        (NORMAL_FRAC_BITS+2)'(1) <<< NORMAL_FRAC_BITS;
    localparam logic signed [NORMAL_FRAC_BITS+1:0] NEG_ONE = -ONE;

    logic accept;
    logic in_range;
    logic all_zero;

    assign accept   = start && !busy;
    assign all_zero = (o_normal_x == '0) && (o_normal_y == '0) && (o_normal_z == '0);
    assign in_range = (o_normal_x <= ONE) && (o_normal_x >= NEG_ONE)
                   && (o_normal_y <= ONE) && (o_normal_y >= NEG_ONE)
                   && (o_normal_z <= ONE) && (o_normal_z >= NEG_ONE)
                   && (i_first_x == i_first_x);

    // Degenerate results carry a zero normal; others a nonzero one in range.
    `TFN_ASSERT_NOW(a_deg_zero, o_valid && o_degenerate, all_zero)
    `TFN_ASSERT_NOW(a_unit_range, o_valid && !o_degenerate, in_range && !all_zero)
    // Each result follows its transaction after a fixed latency.
    `TFN_ASSERT_NOW(a_no_phantom, o_valid, $past(accept, LAT))
    `TFN_ASSERT_NEXT(a_busy_after_reset, !i_rst_n, busy)

endmodule

bind triangle_face_normal tfn_checker #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (.*);

### test/triangle_face_normal_checker.sv
module triangle_face_normal_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_first_x,
    input  logic signed [15:0] i_first_y,
    input  logic signed [15:0] i_first_z,
    input  logic signed [15:0] i_second_x,
    input  logic signed [15:0] i_second_y,
    input  logic signed [15:0] i_second_z,
    input  logic signed [15:0] i_third_x,
    input  logic signed [15:0] i_third_y,
    input  logic signed [15:0] i_third_z,
    input  logic               o_valid,
    input  logic signed [15:0] o_normal_x,
    input  logic signed [15:0] o_normal_y,
    input  logic signed [15:0] o_normal_z,
    input  logic               o_degenerate,
    output int                 fail_count,
    output int                 pending_normals
);

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               deg;
    } t_normal;

    t_normal expected_normals[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_normal face_normal(input logic signed [15:0] v[9]);
        t_normal r;
        logic signed [63:0] e1[3], e2[3], c[3];
        logic [63:0] a[3], m, s, len, q;
        int top, k;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 64'(v[i]) - 64'(v[6+i]);
            e2[i] = 64'(v[6+i]) - 64'(v[3+i]);
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r = '0;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            r.deg = 1'b1;
            return r;
        end
        m = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
            if (a[i] > m) m = a[i];
        end
        top = -1;
        for (int b = 0; b < 64; b++) if (m[b]) top = b;
        k = top - 29;
        for (int i = 0; i < 3; i++) a[i] = (k > 0) ? a[i] >> k : a[i] << -k;
        s   = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << 14) + (len >> 1)) / len;
            if (q > 64'd16384) q = 64'd16384;
            if (c[i] < 0) q = -q;
            if (i == 0) r.nx = q[15:0];
            else if (i == 1) r.ny = q[15:0];
            else r.nz = q[15:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_normals = expected_normals.size();

    always @(posedge i_clk) begin
        logic signed [15:0] verts[9];
        t_normal want;
        if (i_rst_n && start && !busy) begin
            verts = '{i_first_x, i_first_y, i_first_z, i_second_x, i_second_y,
                      i_second_z, i_third_x, i_third_y, i_third_z};
            expected_normals.push_back(face_normal(verts));
        end
        if (i_rst_n && o_valid) begin
            if (expected_normals.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = expected_normals.pop_front();
                if (o_normal_x !== want.nx)
                    report_mismatch($sformatf("normal_x %0d want %0d", o_normal_x, want.nx));
                if (o_normal_y !== want.ny)
                    report_mismatch($sformatf("normal_y %0d want %0d", o_normal_y, want.ny));
                if (o_normal_z !== want.nz)
                    report_mismatch($sformatf("normal_z %0d want %0d", o_normal_z, want.nz));
                if (o_degenerate !== want.deg)
                    report_mismatch($sformatf("degenerate %0b want %0b", o_degenerate, want.deg));
            end
        end
    end

endmodule

### test/triangle_face_normal_tb.sv
module triangle_face_normal_tb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] coord[9];
    logic               o_valid;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;
    logic               o_degenerate;
    int                 fail_count;
    int                 pending_normals;
    int                 cycle_count = 0;

    initial for (int i = 0; i < 9; i++) coord[i] = '0;

    always #1 i_clk = ~i_clk;

    triangle_face_normal DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_x(coord[0]), .i_first_y(coord[1]), .i_first_z(coord[2]),
        .i_second_x(coord[3]), .i_second_y(coord[4]), .i_second_z(coord[5]),
        .i_third_x(coord[6]), .i_third_y(coord[7]), .i_third_z(coord[8]),
        .o_valid(o_valid), .o_normal_x(o_normal_x), .o_normal_y(o_normal_y),
        .o_normal_z(o_normal_z), .o_degenerate(o_degenerate)
    );

    triangle_face_normal_checker normal_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_x(coord[0]), .i_first_y(coord[1]), .i_first_z(coord[2]),
        .i_second_x(coord[3]), .i_second_y(coord[4]), .i_second_z(coord[5]),
        .i_third_x(coord[6]), .i_third_y(coord[7]), .i_third_z(coord[8]),
        .o_valid(o_valid), .o_normal_x(o_normal_x), .o_normal_y(o_normal_y),
        .o_normal_z(o_normal_z), .o_degenerate(o_degenerate),
        .fail_count(fail_count), .pending_normals(pending_normals)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("triangle_face_normal_tb NOT OK");
            $finish;
        end
    end

    // Drive one transaction; start stays high across back-to-back items.
    task automatic send_triangle(input logic signed [15:0] v[9], input bit keep_going);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (!keep_going) begin
            repeat (gap) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        for (int i = 0; i < 9; i++) coord[i] <= v[i];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_coord(input int shape);
        case (shape)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 31)) - 16'sd16;
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 2047)) - 16'sd1024;
        endcase
    endfunction

    initial begin
        logic signed [15:0] v[9];
        int shape;
        int t;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: axis-aligned, extremes, degenerate cases.
        v = '{0, 0, 0, 16, 0, 0, 0, 16, 0};
        send_triangle(v, 0);
        v = '{16, 0, 0, 0, 16, 0, 0, 0, 16};
        send_triangle(v, 1);
        v = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
        send_triangle(v, 1);
        v = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
        send_triangle(v, 0);
        v = '{-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767};
        send_triangle(v, 0);
        v = '{32767, -32768, 0, -32768, 32767, 32767, 0, 0, -32768};
        send_triangle(v, 1);
        v = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
        send_triangle(v, 0);
        v = '{32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0};
        send_triangle(v, 0);
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_triangle(v, 0);
        v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
        send_triangle(v, 1);
        v = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
        send_triangle(v, 0);
        v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_triangle(v, 0);

        for (int n = 0; n < 700; n++) begin
            shape = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) v[i] = rand_coord(shape);
            if ($urandom_range(0, 9) == 0) begin
                // Collinear: third = first + 2 * (second - first).
                for (int i = 0; i < 3; i++) begin
                    v[i] = 16'($urandom_range(0, 4095)) - 16'sd2048;
                    v[3+i] = 16'($urandom_range(0, 4095)) - 16'sd2048;
                    v[6+i] = 16'(2 * v[3+i] - v[i]);
                end
            end
            send_triangle(v, $urandom_range(0, 2) == 0);
        end
        start <= 1'b0;

        t = 0;
        while (pending_normals != 0 && t < 5000) begin
            @(posedge i_clk);
            t++;
        end
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending_normals == 0) begin
            $display("triangle_face_normal_tb OK");
        end else begin
            $display("triangle_face_normal_tb NOT OK");
        end
        $finish;
    end

endmodule
